@@ hdl/ps2ht_pkg.sv @@
// ----------------------------------------------------------------------------
// PS/2 host transceiver package
// Shared types, constants and small helper functions.
// ----------------------------------------------------------------------------
package ps2ht_pkg;

    typedef enum logic [1:0] {
        MODE_EDGE  = 2'd0,
        MODE_START = 2'd1,
        MODE_POP   = 2'd2,
        MODE_ABORT = 2'd3
    } t_mode;

    // Index of the last bit of an 11-bit receive frame.
    localparam logic [3:0] FRAME_LAST   = 4'd10;
    // Data bits plus parity driven by the host.
    localparam logic [3:0] TX_DATA_BITS = 4'd9;
    localparam logic [7:0] BAD_MAX      = 8'hFF;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic       drive_bit;
        logic       drive_valid;
        logic       lines_released;
        logic       ack_seen;
        logic       frame_good;
        logic       frame_bad;
        logic [7:0] pop_byte;
        logic       pop_valid;
        logic [7:0] bad_frames;
    } t_rsp;

    function automatic logic odd_parity(input logic [7:0] b);
        return ~(^b);
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

endpackage

@@ hdl/ps2ht_if.sv @@
// ----------------------------------------------------------------------------
// PS/2 host transceiver channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ps2ht_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       line_bit;
    logic [7:0] send_byte;

    modport source (output valid, output mode, output line_bit, output send_byte,
                    input ready);
    modport sink   (input valid, input mode, input line_bit, input send_byte,
                    output ready);
endinterface

interface ps2ht_rsp_if;
    logic       valid;
    logic       ready;
    logic       drive_bit;
    logic       drive_valid;
    logic       lines_released;
    logic       ack_seen;
    logic       frame_good;
    logic       frame_bad;
    logic [7:0] pop_byte;
    logic       pop_valid;
    logic [7:0] bad_frames;

    modport source (output valid, output drive_bit, output drive_valid,
                    output lines_released, output ack_seen, output frame_good,
                    output frame_bad, output pop_byte, output pop_valid,
                    output bad_frames, input ready);
    modport sink   (input valid, input drive_bit, input drive_valid,
                    input lines_released, input ack_seen, input frame_good,
                    input frame_bad, input pop_byte, input pop_valid,
                    input bad_frames, output ready);
endinterface

@@ hdl/ps2ht_ring.sv @@
// ----------------------------------------------------------------------------
// PS/2 host receive ring
// Byte ring with head/tail pointers and a registered read of the head entry.
// ----------------------------------------------------------------------------
module ps2ht_ring
    import ps2ht_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_ctl  i_ctl,
    input  logic [7:0] i_wr_data,
    output logic       o_empty,
    output logic [7:0] o_head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [7:0]    r_rd_data;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // The read port always follows the next head, so the head entry is ready
    // in a register when a pop arrives. A write to that same entry is bypassed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wr_data;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[n_head];
        end
    end

    assign o_empty     = (r_head == r_tail);
    assign o_head_data = r_rd_data;

endmodule

@@ hdl/ps2_host_frame_transceiver_core.sv @@
// ----------------------------------------------------------------------------
// PS/2 host frame transceiver
// Receives keyboard frames into a byte ring and serializes host commands.
// ----------------------------------------------------------------------------
// One request is accepted every clock cycle. Its response appears in the
// output register on the following cycle, and ready stays high unless that
// register holds a response the sink has not yet taken. Each request is a
// keyboard clock edge, a start of a transmit, a pop from the receive ring or
// an abort; all of them are handled by one pass of logic that updates the
// receive and transmit shifters and the ring pointers. The ring is a memory
// of RING_DEPTH bytes whose head entry is kept in a registered read port.
module ps2_host_frame_transceiver_core
    import ps2ht_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ps2ht_req_if.sink      i_req,
    ps2ht_rsp_if.source    o_rsp
);

    logic        r_out_valid;
    t_rsp        r_rsp, n_rsp;
    logic [10:0] r_rx_shift, n_rx_shift;
    logic [3:0]  r_rx_bits, n_rx_bits;
    logic [8:0]  r_tx_shift, n_tx_shift;
    logic [3:0]  r_tx_bits, n_tx_bits;
    logic        r_host_sending, n_host_sending;
    logic [7:0]  r_bad_count, n_bad_count;

    logic        accept;
    logic        ring_empty;
    logic [7:0]  ring_head_data;
    logic [10:0] frame;
    logic [7:0]  rx_byte;
    t_ring_ctl   ring_ctl;
    t_mode       mode;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign mode        = t_mode'(i_req.mode);
    assign frame       = {r_rx_shift[9:0], i_req.line_bit};
    assign rx_byte     = reverse8(frame[9:2]);

    always_comb begin
        n_rx_shift     = r_rx_shift;
        n_rx_bits      = r_rx_bits;
        n_tx_shift     = r_tx_shift;
        n_tx_bits      = r_tx_bits;
        n_host_sending = r_host_sending;
        n_bad_count    = r_bad_count;
        n_rsp          = '0;
        ring_ctl       = '0;
        unique case (mode)
            MODE_EDGE: begin
                if (r_host_sending) begin
                    if (r_tx_bits < TX_DATA_BITS) begin
                        n_rsp.drive_bit   = r_tx_shift[0];
                        n_rsp.drive_valid = 1'b1;
                        n_tx_shift        = {1'b0, r_tx_shift[8:1]};
                        n_tx_bits         = r_tx_bits + 1'b1;
                    end else if (r_tx_bits == TX_DATA_BITS) begin
                        n_rsp.lines_released = 1'b1;
                        n_tx_bits            = r_tx_bits + 1'b1;
                    end else if (!i_req.line_bit) begin
                        n_rsp.ack_seen = 1'b1;
                        n_tx_bits      = '0;
                        n_host_sending = 1'b0;
                    end
                end else if (r_rx_bits == FRAME_LAST) begin
                    // Frame complete: start bit must be low, stop bit high.
                    if (frame[10] || !frame[0]) begin
                        if (r_bad_count != BAD_MAX) begin
                            n_bad_count = r_bad_count + 1'b1;
                        end
                        n_rsp.frame_bad = 1'b1;
                    end else begin
                        ring_ctl.push    = 1'b1;
                        n_rsp.frame_good = 1'b1;
                    end
                    n_rx_shift = '0;
                    n_rx_bits  = '0;
                end else begin
                    n_rx_shift = frame;
                    n_rx_bits  = r_rx_bits + 1'b1;
                end
            end
            MODE_START: begin
                n_tx_shift     = {odd_parity(i_req.send_byte), i_req.send_byte};
                n_tx_bits      = '0;
                n_host_sending = 1'b1;
            end
            MODE_POP: begin
                if (!ring_empty) begin
                    ring_ctl.pop    = 1'b1;
                    n_rsp.pop_byte  = ring_head_data;
                    n_rsp.pop_valid = 1'b1;
                end
            end
            MODE_ABORT: begin
                n_host_sending = 1'b0;
                n_tx_bits      = '0;
            end
            default: ;
        endcase
        n_rsp.bad_frames = n_bad_count;
        if (!accept) begin
            ring_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_rx_shift     <= '0;
            r_rx_bits      <= '0;
            r_tx_shift     <= '0;
            r_tx_bits      <= '0;
            r_host_sending <= 1'b0;
            r_bad_count    <= '0;
        end else begin
            if (accept) begin
                r_out_valid    <= 1'b1;
                r_rx_shift     <= n_rx_shift;
                r_rx_bits      <= n_rx_bits;
                r_tx_shift     <= n_tx_shift;
                r_tx_bits      <= n_tx_bits;
                r_host_sending <= n_host_sending;
                r_bad_count    <= n_bad_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    ps2ht_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ring_ctl),
        .i_wr_data   (rx_byte),
        .o_empty     (ring_empty),
        .o_head_data (ring_head_data)
    );

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.drive_bit      = r_rsp.drive_bit;
    assign o_rsp.drive_valid    = r_rsp.drive_valid;
    assign o_rsp.lines_released = r_rsp.lines_released;
    assign o_rsp.ack_seen       = r_rsp.ack_seen;
    assign o_rsp.frame_good     = r_rsp.frame_good;
    assign o_rsp.frame_bad      = r_rsp.frame_bad;
    assign o_rsp.pop_byte       = r_rsp.pop_byte;
    assign o_rsp.pop_valid      = r_rsp.pop_valid;
    assign o_rsp.bad_frames     = r_rsp.bad_frames;

endmodule

@@ hdl/ps2ht_checker.sv @@
// ----------------------------------------------------------------------------
// PS/2 host transceiver port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module ps2ht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_drive_bit,
    input logic       i_drive_valid,
    input logic       i_lines_released,
    input logic       i_ack_seen,
    input logic       i_frame_good,
    input logic       i_frame_bad,
    input logic [7:0] i_pop_byte,
    input logic       i_pop_valid
);

    // A stalled response must stay valid and keep its pop byte under the sink.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pop_byte))
        else $error("response changed while stalled");

    // Every accepted request produces a response in the next cycle.
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted request gave no response");

    // A request yields at most one kind of event.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $countones({i_drive_valid, i_lines_released, i_ack_seen,
                                    i_frame_good, i_frame_bad, i_pop_valid}) <= 1)
        else $error("more than one event in a response");

    // Data fields are zero when their qualifiers are low.
    a_idle_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pop_valid || i_pop_byte == 8'd0) &&
                        (i_drive_valid || !i_drive_bit))
        else $error("unqualified data field not zero");

    // No response appears without a request behind it.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !(i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("response without a request");

endmodule

bind ps2_host_frame_transceiver_core ps2ht_checker u_ps2ht_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_drive_bit      (o_rsp.drive_bit),
    .i_drive_valid    (o_rsp.drive_valid),
    .i_lines_released (o_rsp.lines_released),
    .i_ack_seen       (o_rsp.ack_seen),
    .i_frame_good     (o_rsp.frame_good),
    .i_frame_bad      (o_rsp.frame_bad),
    .i_pop_byte       (o_rsp.pop_byte),
    .i_pop_valid      (o_rsp.pop_valid)
);
